// ===== rtl/rcm_pkg.sv =====
`default_nettype none

package rcm_pkg;

  // fixed field widths
  localparam int SIZE_W     = 13;
  localparam int IDX_W      = 12;
  localparam int WGT_W      = 17;
  localparam int MODE_W     = 3;
  localparam int RND_W      = 2;
  localparam int CFG_ADDR_W = 3;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_IN_SIZE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_OUT_SIZE   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_COORD_MODE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROUND_MODE = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_INTERP     = 3'd4;

  // coordinate transform modes
  localparam logic [MODE_W-1:0] CM_HALF    = 3'd0;
  localparam logic [MODE_W-1:0] CM_PYTORCH = 3'd1;
  localparam logic [MODE_W-1:0] CM_ALIGN   = 3'd2;
  localparam logic [MODE_W-1:0] CM_ASYM    = 3'd3;
  localparam logic [MODE_W-1:0] CM_TFNN    = 3'd4;

  // nearest rounding rules
  localparam logic [RND_W-1:0] RM_NEAR_FLOOR = 2'd0;
  localparam logic [RND_W-1:0] RM_NEAR_CEIL  = 2'd1;
  localparam logic [RND_W-1:0] RM_FLOOR      = 2'd2;
  localparam logic [RND_W-1:0] RM_CEIL       = 2'd3;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_RUN
  } div_state_t;

  // static mapping controls handed to the pipeline
  typedef struct packed {
    logic [MODE_W-1:0] coord_mode;
    logic [RND_W-1:0]  round_mode;
    logic              interp;
    logic [SIZE_W-1:0] isz;
    logic              osz_gt1;
  } map_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/rcm_scale_div.sv =====
`default_nettype none

module rcm_scale_div import rcm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        restart,
  input  wire logic [SIZE_W-1:0]           num,
  input  wire logic [SIZE_W-1:0]           den,
  output logic                             busy,
  output logic [SIZE_W+FRAC_BITS-1:0]      scale
);

  localparam int DW = SIZE_W + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  div_state_t        state_r, state_nxt;
  logic [DW-1:0]     dvd_r, dvd_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [DW-1:0]     quot_r, quot_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              dz_r, dz_nxt;
  logic [DW-1:0]     scale_r, scale_nxt;

  logic [SIZE_W:0]   rem_sh;
  logic [SIZE_W:0]   rem_diff;
  logic              ge;
  logic [DW-1:0]     quot_step;

  // one restoring step per cycle
  assign rem_sh    = {rem_r, dvd_r[DW-1]};
  assign rem_diff  = rem_sh - {1'b0, den};
  assign ge        = (rem_sh >= {1'b0, den});
  assign quot_step = {quot_r[DW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    quot_r  <= quot_nxt;
    cnt_r   <= cnt_nxt;
    dz_r    <= dz_nxt;
    scale_r <= scale_nxt;
  end

  // sequencer: load after any register write, then shift out the quotient
  always_comb begin
    state_nxt = state_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    quot_nxt  = quot_r;
    cnt_nxt   = cnt_r;
    dz_nxt    = dz_r;
    scale_nxt = scale_r;
    priority if (restart) begin
      state_nxt = DIV_LOAD;
    end else begin
      unique case (state_r)
        DIV_LOAD: begin
          dvd_nxt   = {num, {FRAC_BITS{1'b0}}};
          rem_nxt   = '0;
          quot_nxt  = '0;
          cnt_nxt   = CW'(DW);
          dz_nxt    = (den == '0);
          state_nxt = DIV_RUN;
        end
        DIV_RUN: begin
          dvd_nxt  = {dvd_r[DW-2:0], 1'b0};
          rem_nxt  = ge ? rem_diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
          quot_nxt = quot_step;
          cnt_nxt  = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            scale_nxt = dz_r ? '0 : quot_step;
            state_nxt = DIV_IDLE;
          end
        end
        DIV_IDLE: begin
          state_nxt = DIV_IDLE;
        end
        default: begin
          state_nxt = DIV_LOAD;
        end
      endcase
    end
  end

  assign busy  = (state_r != DIV_IDLE);
  assign scale = scale_r;

endmodule

`default_nettype wire

// ===== rtl/rcm_map_pipe.sv =====
`default_nettype none

module rcm_map_pipe import rcm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [IDX_W-1:0]            in_index,
  input  wire logic [SIZE_W+FRAC_BITS-1:0] scale,
  input  wire map_cfg_t                    cfg,
  output logic                             out_valid,
  output logic [IDX_W-1:0]                 out_src_index,
  output logic [WGT_W-1:0]                 out_weight_left,
  output logic [WGT_W-1:0]                 out_weight_right,
  output logic                             out_unsup
);

  localparam int DW = SIZE_W + FRAC_BITS;
  localparam int MW = IDX_W + 1;
  localparam int PW = MW + DW;
  localparam int FW = PW + 1;
  localparam int LW = FW - FRAC_BITS;
  localparam int WW = (FRAC_BITS + 1 > WGT_W) ? FRAC_BITS + 1 : WGT_W;

  localparam logic [FW-1:0]        HALF_FX = FW'(64'd1 << (FRAC_BITS - 1));
  localparam logic [FRAC_BITS-1:0] HALF_FR = FRAC_BITS'(64'd1 << (FRAC_BITS - 1));
  localparam logic [WW-1:0]        ONE_W   = WW'(64'd1 << FRAC_BITS);

  // stage 1: captured index
  logic                  s1_v_r;
  logic [IDX_W-1:0]      s1_idx_r;
  // stage 2: product
  logic                  s2_v_r;
  logic [PW-1:0]         s2_prod_r, s2_prod_nxt;
  logic [MW-1:0]         mult;
  // stage 3: floor and fraction
  logic                  s3_v_r;
  logic signed [LW-1:0]  s3_fl_r, s3_fl_nxt;
  logic [FRAC_BITS-1:0]  s3_fr_r, s3_fr_nxt;
  logic [PW-1:0]         half_prod;
  logic signed [FW-1:0]  fx;
  // output register
  logic                  o_v_r;
  logic [IDX_W-1:0]      o_idx_r, o_idx_nxt;
  logic [WGT_W-1:0]      o_wl_r, o_wl_nxt;
  logic [WGT_W-1:0]      o_wr_r, o_wr_nxt;
  logic                  o_un_r, o_un_nxt;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      o_v_r  <= s3_v_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_idx_r  <= in_index;
    s2_prod_r <= s2_prod_nxt;
    s3_fl_r   <= s3_fl_nxt;
    s3_fr_r   <= s3_fr_nxt;
    o_idx_r   <= o_idx_nxt;
    o_wl_r    <= o_wl_nxt;
    o_wr_r    <= o_wr_nxt;
    o_un_r    <= o_un_nxt;
  end

  // stage 2: d or 2d+1 times scale
  always_comb begin
    if (cfg.coord_mode == CM_ALIGN || cfg.coord_mode == CM_ASYM) begin
      mult = {1'b0, s1_idx_r};
    end else begin
      mult = {s1_idx_r, 1'b1};
    end
    s2_prod_nxt = {{DW{1'b0}}, mult} * {{MW{1'b0}}, scale};
  end

  // stage 3: source coordinate, split into floor and fraction
  assign half_prod = s2_prod_r >> 1;

  always_comb begin
    unique case (cfg.coord_mode)
      CM_HALF:    fx = $signed({1'b0, half_prod} - HALF_FX);
      CM_PYTORCH: fx = cfg.osz_gt1 ? $signed({1'b0, half_prod} - HALF_FX) : '0;
      CM_ALIGN,
      CM_ASYM:    fx = $signed({1'b0, s2_prod_r});
      CM_TFNN:    fx = $signed({1'b0, half_prod});
      default:    fx = '0;
    endcase
    s3_fl_nxt = fx[FW-1:FRAC_BITS];
    s3_fr_nxt = fx[FRAC_BITS-1:0];
  end

  // stage 4: rounding or edge handling, clamp, weights
  always_comb begin
    logic signed [LW-1:0] isz_s;
    logic signed [LW-1:0] idx;
    logic                 inc;
    logic [WW-1:0]        frw;
    logic [WW-1:0]        wl;
    logic [WW-1:0]        wr;

    isz_s = $signed({{(LW-SIZE_W){1'b0}}, cfg.isz});
    idx   = s3_fl_r;
    inc   = 1'b0;
    frw   = {{(WW-FRAC_BITS){1'b0}}, s3_fr_r};
    wl    = ONE_W;
    wr    = '0;
    if (!cfg.interp) begin
      unique case (cfg.round_mode)
        RM_NEAR_FLOOR: inc = (s3_fr_r > HALF_FR);
        RM_NEAR_CEIL:  inc = (s3_fr_r >= HALF_FR);
        RM_FLOOR:      inc = 1'b0;
        RM_CEIL:       inc = (s3_fr_r != '0);
        default:       inc = 1'b0;
      endcase
      idx = s3_fl_r + $signed({{(LW-1){1'b0}}, inc});
      if (idx < 0) begin
        idx = '0;
      end else if (idx > isz_s - $signed(LW'(1))) begin
        idx = isz_s - $signed(LW'(1));
      end
    end else begin
      if (idx < 0) begin
        idx = '0;
        frw = '0;
      end
      if (cfg.isz == SIZE_W'(1)) begin
        idx = '0;
        frw = '0;
      end else if (idx >= isz_s - $signed(LW'(1))) begin
        idx = isz_s - $signed(LW'(2));
        frw = ONE_W;
      end
      wl = ONE_W - frw;
      wr = frw;
    end
    o_idx_nxt = idx[IDX_W-1:0];
    o_wl_nxt  = wl[WGT_W-1:0];
    o_wr_nxt  = wr[WGT_W-1:0];
    o_un_nxt  = (cfg.coord_mode > CM_TFNN);
  end

  assign out_valid        = o_v_r;
  assign out_src_index    = o_idx_r;
  assign out_weight_left  = o_wl_r;
  assign out_weight_right = o_wr_r;
  assign out_unsup        = o_un_r;

endmodule

`default_nettype wire

// ===== rtl/resize_coordinate_mapper_core.sv =====
// out_valid rises once an accepted item has passed the s1, s2, s3 and output registers.
// Throughput: one item per clock while busy is low, through a four-register pipeline; the receiver cannot stall.
// Scale is formed by a one-bit-per-cycle divider: busy stays high after reset and after
// every register write until the division has finished.
// Reset (rst_n low, synchronous) loads in_size 1, out_size 1, other registers 0,
// clears the pipeline and starts the scale division.
`default_nettype none

module resize_coordinate_mapper_core import rcm_pkg::*; #(
  parameter int MAX_SIZE  = 4096,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [IDX_W-1:0]      in_out_index,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [SIZE_W-1:0]     cfg_wdata,
  output logic                       out_valid,
  output logic [IDX_W-1:0]           out_src_index,
  output logic [WGT_W-1:0]           out_weight_left,
  output logic [WGT_W-1:0]           out_weight_right,
  output logic                       out_mode_unsupported
);

  localparam int DW = SIZE_W + FRAC_BITS;

  logic [SIZE_W-1:0] cfg_in_size_r;
  logic [SIZE_W-1:0] cfg_out_size_r;
  logic [MODE_W-1:0] cfg_coord_r;
  logic [RND_W-1:0]  cfg_round_r;
  logic              cfg_interp_r;

  logic [SIZE_W-1:0] isz_sat;
  logic [SIZE_W-1:0] isz;
  logic [SIZE_W-1:0] osz;
  logic [SIZE_W-1:0] num;
  logic [SIZE_W-1:0] den;
  logic [DW-1:0]     scale;
  logic              div_busy;
  logic              accept;
  map_cfg_t          map_cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_in_size_r  <= SIZE_W'(1);
      cfg_out_size_r <= SIZE_W'(1);
      cfg_coord_r    <= '0;
      cfg_round_r    <= '0;
      cfg_interp_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IN_SIZE:    cfg_in_size_r  <= cfg_wdata;
        CFG_OUT_SIZE:   cfg_out_size_r <= cfg_wdata;
        CFG_COORD_MODE: cfg_coord_r    <= cfg_wdata[MODE_W-1:0];
        CFG_ROUND_MODE: cfg_round_r    <= cfg_wdata[RND_W-1:0];
        CFG_INTERP:     cfg_interp_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // size saturation and scale operands
  always_comb begin
    isz_sat = (32'(cfg_in_size_r) > MAX_SIZE) ? SIZE_W'(MAX_SIZE) : cfg_in_size_r;
    osz     = (32'(cfg_out_size_r) > MAX_SIZE) ? SIZE_W'(MAX_SIZE) : cfg_out_size_r;
    isz     = (isz_sat == '0) ? SIZE_W'(1) : isz_sat;
    if (cfg_coord_r == CM_ALIGN) begin
      num = isz - SIZE_W'(1);
      den = (osz == '0) ? '0 : osz - SIZE_W'(1);
    end else begin
      num = isz;
      den = osz;
    end
    map_cfg.coord_mode = cfg_coord_r;
    map_cfg.round_mode = cfg_round_r;
    map_cfg.interp     = cfg_interp_r;
    map_cfg.isz        = isz;
    map_cfg.osz_gt1    = (osz > SIZE_W'(1));
  end

  rcm_scale_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_we),
    .num     (num),
    .den     (den),
    .busy    (div_busy),
    .scale   (scale)
  );

  assign busy   = div_busy;
  assign accept = start && !div_busy;

  rcm_map_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pipe (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (accept),
    .in_index         (in_out_index),
    .scale            (scale),
    .cfg              (map_cfg),
    .out_valid        (out_valid),
    .out_src_index    (out_src_index),
    .out_weight_left  (out_weight_left),
    .out_weight_right (out_weight_right),
    .out_unsup        (out_mode_unsupported)
  );

  // every result traces back to an accepted item that passed the s1, s2, s3 and output registers
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 4))
    else $error("result without accepted item");

  // a register write always restarts the scale division
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("busy not raised after register write");

  // nearest mapping never weights the right tap
  a_nearest_wr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(cfg_interp_r) |-> out_weight_right == '0)
    else $error("nearest result with right weight");

  // linear weights add up to one when they fit the field
  a_linear_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(cfg_interp_r) && (FRAC_BITS <= 16)
      |-> (18'(out_weight_left) + 18'(out_weight_right)) == 18'(64'd1 << FRAC_BITS))
    else $error("linear weights do not sum to one");

endmodule

`default_nettype wire
